// File: rtl/hls_pkg.sv
// Package for the href link scanner: result kinds, scan phases, quote modes,
// the result record and the byte classification helpers.
// No dependencies; the scanner core, the result queue and the testbench import it.
package hls_pkg;

	localparam logic [7:0]  CH_H          = 8'h68;
	localparam logic [7:0]  CH_R          = 8'h72;
	localparam logic [7:0]  CH_E          = 8'h65;
	localparam logic [7:0]  CH_F          = 8'h66;
	localparam logic [7:0]  CH_DQUOTE     = 8'h22;
	localparam logic [7:0]  CH_SQUOTE     = 8'h27;
	localparam logic [7:0]  CH_SPACE      = 8'h20;
	localparam logic [7:0]  CH_TAB        = 8'h09;
	localparam logic [7:0]  CH_LF         = 8'h0A;
	localparam logic [7:0]  CH_CR         = 8'h0D;
	localparam logic [7:0]  CH_GT         = 8'h3E;
	localparam logic [7:0]  CH_EQ         = 8'h3D;
	localparam logic [7:0]  CH_NUL        = 8'h00;
	localparam logic [11:0] MAX_LEN_RESET = 12'd599;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// The first four phases count the letters of "href" matched so far.
	typedef enum logic [2:0] {
		PH_H       = 3'd0,
		PH_R       = 3'd1,
		PH_E       = 3'd2,
		PH_F       = 3'd3,
		PH_PRE_EQ  = 3'd4,
		PH_POST_EQ = 3'd5,
		PH_VALUE   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  link_byte;
		logic [15:0] link_count;
		logic        last;
	} result_t;

	// Zero, one or two results produced by one accepted beat.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t make_result(kind_t kind, logic [7:0] b,
			logic [15:0] count, logic last);
		result_t r;
		r.kind       = kind;
		r.link_byte  = b;
		r.link_count = count;
		r.last       = last;
		return r;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	// Advances the search for "href" by one byte.
	function automatic phase_t search_next(phase_t ph, logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] want;
		logic       letter;
		lc     = to_lower(c);
		want   = CH_H;
		letter = 1'b1;
		unique case (ph)
			PH_H:    want = CH_H;
			PH_R:    want = CH_R;
			PH_E:    want = CH_E;
			PH_F:    want = CH_F;
			default: letter = 1'b0;
		endcase
		if (letter && lc == want) begin
			return phase_t'(ph + 3'd1);
		end
		return (lc == CH_H) ? PH_R : PH_H;
	endfunction

endpackage

// File: rtl/hls_in_if.sv
// Input channel of the href link scanner: one body byte or end marker per beat.
// Depends on nothing.
interface hls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_body;

	modport source (output valid, output data_byte, output end_of_body, input ready);
	modport sink (input valid, input data_byte, input end_of_body, output ready);
endinterface

// File: rtl/hls_out_if.sv
// Result channel of the href link scanner: one result record per beat.
// Depends on nothing.
interface hls_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  link_byte;
	logic [15:0] link_count;
	logic        last;

	modport source (output valid, output kind, output link_byte, output link_count,
		output last, input ready);
	modport sink (input valid, input kind, input link_byte, input link_count,
		input last, output ready);
endinterface

// File: rtl/href_link_scanner_core.sv
// Top level of the href link scanner: scan state machine, length register
// and result queue. Depends on hls_pkg, hls_in_if, hls_out_if, hls_result_fifo.
//
// The scanner takes one body byte per beat on in_ch and looks for href
// attribute values, matching the word href without regard to case, then
// blanks, '=', blanks, and a double-quoted, single-quoted or unquoted value.
// Every captured value byte leaves on out_ch as a byte result, and every
// non-empty value is closed by a link-end result carrying the saturating
// link count. A zero byte halts scanning until the end-of-body beat, which
// closes an open value and reports the count, then clears the scan state
// for the next body. A value that reaches max_link_len is closed right after
// its last byte. The scan state advances in the cycle a beat is accepted,
// and its results land in a queue of FIFO_DEPTH entries whose head drives
// out_ch, so a result is offered once the results ahead of it have left. The input takes
// one beat per cycle as long as the queue has room for two results, which
// with an output that is always ready means one byte per clock; a beat
// that yields two results (a value cut at its length limit, or an open
// value closed by end of body) adds one queued result, and the queue
// depth sets how many of those can be absorbed back to back before the
// input stalls. max_link_len is written with cfg_we and cfg_wdata; a value
// of zero acts as one. Write it only while the block is idle.
module href_link_scanner_core #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	hls_in_if.sink      in_ch,
	hls_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);
	import hls_pkg::*;

	logic [11:0] max_len_q;
	phase_t      phase_q, phase_d;
	quote_t      quote_q, quote_d;
	logic [11:0] vlen_q, vlen_d;
	logic [15:0] count_q, count_d;
	logic        halted_q, halted_d;

	logic        in_acc;
	logic        pop;
	logic        room_for_two;
	logic        head_valid;
	result_t     head;
	push_t       push;

	logic [7:0]  c;
	logic [11:0] limit;
	logic [15:0] count_inc;
	logic [11:0] cap_len;
	logic        cap_hit;
	logic        stop;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign in_ch.ready = room_for_two;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.data_byte;
	assign limit       = (max_len_q == 12'd0) ? 12'd1 : max_len_q;
	assign count_inc   = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

	// Length after capturing this byte: a value starts from zero after '='.
	assign cap_len = ((phase_q == PH_VALUE) ? vlen_q : 12'd0) + 12'd1;
	assign cap_hit = (cap_len >= limit);

	always_comb begin
		unique case (quote_q)
			Q_DOUBLE: stop = (c == CH_DQUOTE);
			Q_SINGLE: stop = (c == CH_SQUOTE);
			default:  stop = is_blank(c) || (c == CH_GT);
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		quote_d  = quote_q;
		vlen_d   = vlen_q;
		count_d  = count_q;
		halted_d = halted_q;
		push     = '0;

		if (in_acc) begin
			if (in_ch.end_of_body) begin
				// Close an open non-empty value first, then report the count.
				if (phase_q == PH_VALUE && !halted_q && vlen_q != 12'd0) begin
					push.n  = 2'd2;
					push.r0 = make_result(KIND_END, 8'd0, count_inc, 1'b0);
					push.r1 = make_result(KIND_DONE, 8'd0, count_inc, 1'b1);
				end else begin
					push.n  = 2'd1;
					push.r0 = make_result(KIND_DONE, 8'd0, count_q, 1'b1);
				end
				phase_d  = PH_H;
				quote_d  = Q_NONE;
				vlen_d   = 12'd0;
				count_d  = 16'd0;
				halted_d = 1'b0;
			end else if (!halted_q) begin
				priority if (c == CH_NUL) begin
					if (phase_q == PH_VALUE && vlen_q != 12'd0) begin
						push.n  = 2'd1;
						push.r0 = make_result(KIND_END, 8'd0, count_inc, 1'b1);
						count_d = count_inc;
					end
					phase_d  = PH_H;
					quote_d  = Q_NONE;
					vlen_d   = 12'd0;
					halted_d = 1'b1;
				end else if ((phase_q == PH_VALUE && !stop) ||
						(phase_q == PH_POST_EQ && !is_blank(c) && c != CH_DQUOTE &&
						c != CH_SQUOTE && c != CH_GT)) begin
					// Capture one value byte, closing the value at the limit.
					push.r0 = make_result(KIND_BYTE, c, count_q, !cap_hit);
					if (cap_hit) begin
						push.n  = 2'd2;
						push.r1 = make_result(KIND_END, 8'd0, count_inc, 1'b1);
						count_d = count_inc;
						phase_d = PH_H;
						quote_d = Q_NONE;
						vlen_d  = 12'd0;
					end else begin
						push.n  = 2'd1;
						phase_d = PH_VALUE;
						vlen_d  = cap_len;
						if (phase_q == PH_POST_EQ) begin
							quote_d = Q_NONE;
						end
					end
				end else if (phase_q == PH_VALUE) begin
					// Closing quote or terminator.
					if (vlen_q != 12'd0) begin
						push.n  = 2'd1;
						push.r0 = make_result(KIND_END, 8'd0, count_inc, 1'b1);
						count_d = count_inc;
					end
					phase_d = PH_H;
					quote_d = Q_NONE;
					vlen_d  = 12'd0;
				end else if (phase_q == PH_POST_EQ) begin
					if (c == CH_DQUOTE) begin
						quote_d = Q_DOUBLE;
						phase_d = PH_VALUE;
						vlen_d  = 12'd0;
					end else if (c == CH_SQUOTE) begin
						quote_d = Q_SINGLE;
						phase_d = PH_VALUE;
						vlen_d  = 12'd0;
					end else if (c == CH_GT) begin
						quote_d = Q_NONE;
						phase_d = PH_H;
						vlen_d  = 12'd0;
					end
				end else if (phase_q == PH_PRE_EQ) begin
					if (c == CH_EQ) begin
						phase_d = PH_POST_EQ;
					end else if (!is_blank(c)) begin
						// No '=': the byte may start a new href.
						phase_d = search_next(PH_H, c);
					end
				end else begin
					phase_d = search_next(phase_q, c);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_H;
			quote_q  <= Q_NONE;
			vlen_q   <= 12'd0;
			count_q  <= 16'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			quote_q  <= quote_d;
			vlen_q   <= vlen_d;
			count_q  <= count_d;
			halted_q <= halted_d;
		end
	end

	assign pop = head_valid && out_ch.ready;

	hls_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_result_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pop          (pop),
		.head         (head),
		.head_valid   (head_valid),
		.room_for_two (room_for_two)
	);

	assign out_ch.valid      = head_valid;
	assign out_ch.kind       = head.kind;
	assign out_ch.link_byte  = head.link_byte;
	assign out_ch.link_count = head.link_count;
	assign out_ch.last       = head.last;

	// A halted scanner produces nothing until the end-of-body beat.
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && halted_q && !in_ch.end_of_body |-> push.n == 2'd0)
		else $error("halted scanner produced a result");

	// Only the second of two results from one beat carries last.
	a_last_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> !push.r0.last && push.r1.last)
		else $error("last flag misplaced on a two-result beat");

	// End of body leaves a clean scanner for the next body.
	a_body_reset: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.end_of_body |=> count_q == 16'd0 && phase_q == PH_H && !halted_q)
		else $error("scan state not cleared after end of body");

	// A beat is accepted only with room for both of its possible results.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room_for_two)
		else $error("result pushed without room in the queue");

endmodule

// File: rtl/hls_result_fifo.sv
// Small result queue of the href link scanner: takes up to two results a cycle
// and hands out one. Depends on hls_pkg.
module hls_result_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hls_pkg::push_t   push,
	input  logic             pop,
	output hls_pkg::result_t head,
	output logic             head_valid,
	output logic             room_for_two
);
	import hls_pkg::*;

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_ptr_nx;

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_nx    = ptr_inc(wr_ptr_q);
	assign head         = mem_q[rd_ptr_q];
	assign head_valid   = (count_q != '0);
	assign room_for_two = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.n == 2'd1) begin
				wr_ptr_q <= wr_ptr_nx;
			end else if (push.n == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_nx);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for href_link_scanner_core: a short table of beats with
// some results written out, then random page bodies checked against a built-in scanner.
// Depends on hls_pkg, hls_in_if, hls_out_if and the scanner RTL.
module tb_top;
	import hls_pkg::*;

	// Run shape. A phase is one max_link_len setting followed by random bodies.
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 210;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_WAIT      = 16;
	localparam int CYCLE_LIMIT   = 400000;

	// Settings in phase order. Entries 5 and 7 are replaced by random lengths at run time.
	localparam logic [11:0] LEN_PLAN [PHASES] = '{12'd1, 12'd0, 12'd4095, 12'd2, 12'd7,
		12'd0, 12'd599, 12'd0};

	localparam logic [7:0] HREF_WORD [4] = '{CH_H, CH_R, CH_E, CH_F};

	// One beat to send. Where typed is set, the result written in the row is the one
	// expected (a single result with last set), instead of what the scanner model says.
	typedef struct packed {
		logic [7:0]  b;
		logic        eob;
		logic        typed;
		kind_t       kind;
		logic [7:0]  lb;
		logic [15:0] cnt;
	} beat_row_t;

	// Opening beats, right after reset with the reset length of 599.
	localparam int OPENING_ROWS = 31;
	localparam beat_row_t OPENING [OPENING_ROWS] = '{
		'{8'h00,     1'b1, 1'b1, KIND_DONE, 8'h00, 16'd0},  // empty body reports zero
		'{8'h48,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // "HrEF" in mixed case
		'{CH_R,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{8'h45,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{8'h46,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_SPACE,  1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_EQ,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_TAB,    1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_SQUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{8'hFF,     1'b0, 1'b1, KIND_BYTE, 8'hFF, 16'd0},  // top byte value is captured
		'{CH_LF,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // blanks belong to a quoted value
		'{CH_SQUOTE, 1'b0, 1'b1, KIND_END,  8'h00, 16'd1},
		'{CH_H,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_R,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_E,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_F,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_H,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // no '=', so this h starts over
		'{CH_R,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_E,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_F,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_EQ,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_GT,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // empty value, nothing counted
		'{CH_H,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_R,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_E,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_F,      1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{CH_EQ,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
		'{8'h61,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // unquoted value
		'{CH_NUL,    1'b0, 1'b1, KIND_END,  8'h00, 16'd2},  // zero byte closes it and halts
		'{8'h7A,     1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},  // ignored while halted
		'{8'h00,     1'b1, 1'b1, KIND_DONE, 8'h00, 16'd2}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [11:0] cfg_wdata;

	hls_in_if  in_ch();
	hls_out_if out_ch();

	href_link_scanner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Scanner model state, kept in step with every accepted beat.
	phase_t      scan_ph     = PH_H;
	quote_t      quoting     = Q_NONE;
	logic [11:0] value_len   = '0;
	logic [15:0] link_total  = '0;
	logic        halted_flag = 1'b0;
	logic [11:0] len_limit   = MAX_LEN_RESET;

	result_t   beat_results[$];   // results of the beat being modeled
	result_t   pending_links[$];  // results still to come out of the block
	beat_row_t beat_notes[$];     // rows on offer, oldest first

	int          errors      = 0;
	int          counted     = 0;
	logic        steady      = 1'b0;
	logic        hold_request = 1'b0;
	int unsigned cycle_count = 0;

	function automatic logic is_gap(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic void note_result(input kind_t k, input logic [7:0] b);
		beat_results.push_back('{kind: k, link_byte: b, link_count: link_total, last: 1'b0});
	endfunction

	// Ends the value being captured; only a non-empty one is counted and reported.
	function automatic void close_value();
		if (value_len != 0) begin
			if (link_total != COUNT_MAX)
				link_total = link_total + 16'd1;
			note_result(KIND_END, 8'h00);
		end
		value_len = '0;
		quoting = Q_NONE;
		scan_ph = PH_H;
	endfunction

	// A limit of zero behaves as one; the byte that reaches the limit still goes out.
	function automatic void take_byte(input logic [7:0] c);
		logic [11:0] lim;
		lim = (len_limit == 0) ? 12'd1 : len_limit;
		note_result(KIND_BYTE, c);
		value_len = value_len + 12'd1;
		if (value_len >= lim)
			close_value();
	endfunction

	function automatic void advance_search(input logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
		if (scan_ph < PH_PRE_EQ && lc == HREF_WORD[scan_ph[1:0]])
			scan_ph = phase_t'(scan_ph + 3'd1);
		else
			scan_ph = (lc == CH_H) ? PH_R : PH_H;
	endfunction

	// Works out the results of one accepted beat into beat_results.
	function automatic void scan_beat(input logic [7:0] c, input logic eob);
		result_t tail;
		beat_results.delete();
		if (eob) begin
			if (scan_ph == PH_VALUE && !halted_flag)
				close_value();
			note_result(KIND_DONE, 8'h00);
			scan_ph = PH_H;
			quoting = Q_NONE;
			value_len = '0;
			link_total = '0;
			halted_flag = 1'b0;
		end else if (!halted_flag) begin
			if (c == CH_NUL) begin
				if (scan_ph == PH_VALUE)
					close_value();
				scan_ph = PH_H;
				quoting = Q_NONE;
				value_len = '0;
				halted_flag = 1'b1;
			end else begin
				case (scan_ph)
					PH_VALUE: begin
						if ((quoting == Q_DOUBLE && c == CH_DQUOTE) ||
								(quoting == Q_SINGLE && c == CH_SQUOTE) ||
								(quoting == Q_NONE && (is_gap(c) || c == CH_GT)))
							close_value();
						else
							take_byte(c);
					end
					PH_PRE_EQ: begin
						if (c == CH_EQ) begin
							scan_ph = PH_POST_EQ;
						end else if (!is_gap(c)) begin
							// Not an '=': the byte is looked at again as body text.
							scan_ph = PH_H;
							advance_search(c);
						end
					end
					PH_POST_EQ: begin
						if (!is_gap(c)) begin
							value_len = '0;
							if (c == CH_DQUOTE) begin
								quoting = Q_DOUBLE;
								scan_ph = PH_VALUE;
							end else if (c == CH_SQUOTE) begin
								quoting = Q_SINGLE;
								scan_ph = PH_VALUE;
							end else if (c == CH_GT) begin
								quoting = Q_NONE;
								scan_ph = PH_H;
							end else begin
								quoting = Q_NONE;
								scan_ph = PH_VALUE;
								take_byte(c);
							end
						end
					end
					default: advance_search(c);
				endcase
			end
		end
		if (beat_results.size() != 0) begin
			tail = beat_results.pop_back();
			tail.last = 1'b1;
			beat_results.push_back(tail);
		end
	endfunction

	function automatic void flag_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Watchdog: a lost result or a stuck handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	// Result receiver. It normally drops ready about a quarter of the time, stays
	// ready throughout a steady phase, and once holds off for a long stretch so
	// that the result queue fills and the input stalls behind it.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ch.ready <= steady || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// updates land. Input beats are handled first so that the expectations of a
	// beat are in place before anything that could be compared with them.
	always @(posedge clk) begin : watch
		beat_row_t row;
		result_t   want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				row = beat_notes.pop_front();
				scan_beat(in_ch.data_byte, in_ch.end_of_body);
				if (row.typed)
					pending_links.push_back('{kind: row.kind, link_byte: row.lb,
						link_count: row.cnt, last: 1'b1});
				else
					foreach (beat_results[i])
						pending_links.push_back(beat_results[i]);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_links.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d byte %h count %0d",
						$time, out_ch.kind, out_ch.link_byte, out_ch.link_count);
					errors++;
				end else begin
					want = pending_links.pop_front();
					flag_field("kind", 16'(want.kind), 16'(out_ch.kind));
					flag_field("link_byte", 16'(want.link_byte), 16'(out_ch.link_byte));
					flag_field("link_count", want.link_count, out_ch.link_count);
					flag_field("last", 16'(want.last), 16'(out_ch.last));
				end
			end
		end
	end

	// Offers one beat, with random idle cycles ahead of it outside a steady phase,
	// and returns at the edge where it is taken. Every beat counts toward the
	// phase length, whether or not the body is halted.
	task automatic drive_beat(input beat_row_t row);
		while (!steady && $urandom_range(0, 99) < 24) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		beat_notes.push_back(row);
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= row.b;
		in_ch.end_of_body <= row.eob;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		counted++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		drive_beat('{b: c, eob: 1'b0, typed: 1'b0, kind: KIND_BYTE, lb: 8'h00, cnt: 16'd0});
	endtask

	// The byte that goes with an end marker is ignored, so it is left random.
	task automatic send_eob();
		drive_beat('{b: 8'($urandom_range(0, 255)), eob: 1'b1, typed: 1'b0,
			kind: KIND_BYTE, lb: 8'h00, cnt: 16'd0});
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// One href attribute with random letter case, blanks and quoting. Value lengths
	// cluster around the length limit when it is short, so that cut-off values
	// and the bytes after them come up often. Now and then the '=' is missing or
	// the value is left open, closed by a zero byte or closed by the end of body.
	task automatic send_href_attr();
		quote_t     q;
		int         n;
		int         lim;
		int         pick;
		logic [7:0] c;
		for (int i = 0; i < 4; i++) begin
			c = HREF_WORD[i];
			if ($urandom_range(0, 1))
				c = c & 8'hDF;
			send_byte(c);
		end
		repeat ($urandom_range(0, 2)) send_byte(blank_char());
		if ($urandom_range(0, 99) < 8) begin
			send_byte(8'($urandom_range(1, 255)));
			return;
		end
		send_byte(CH_EQ);
		repeat ($urandom_range(0, 2)) send_byte(blank_char());
		q = quote_t'($urandom_range(0, 2));
		lim = (len_limit == 0) ? 1 : int'(len_limit);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			n = $urandom_range(0, 6);
		else if (pick < 85 && lim <= 40)
			n = $urandom_range(lim > 1 ? lim - 1 : 0, lim + 3);
		else
			n = $urandom_range(0, 24);
		if (q == Q_DOUBLE)
			send_byte(CH_DQUOTE);
		else if (q == Q_SINGLE)
			send_byte(CH_SQUOTE);
		repeat (n) begin
			c = 8'($urandom_range(1, 255));
			if ((q == Q_DOUBLE && c == CH_DQUOTE) || (q == Q_SINGLE && c == CH_SQUOTE) ||
					(q == Q_NONE && (c == CH_DQUOTE || c == CH_SQUOTE || is_gap(c) ||
					c == CH_GT)))
				c = 8'h2F;
			send_byte(c);
		end
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			if (q == Q_DOUBLE)
				send_byte(CH_DQUOTE);
			else if (q == Q_SINGLE)
				send_byte(CH_SQUOTE);
			else if ($urandom_range(0, 1))
				send_byte(CH_GT);
			else
				send_byte(blank_char());
		end else if (pick < 88) begin
			send_byte(CH_NUL);
		end else if (pick < 95) begin
			send_eob();
		end
	endtask

	// Mostly attributes; the rest is plain text, end markers, halted bodies and
	// words that stop short of href.
	task automatic send_fragment();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			send_href_attr();
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)));
		end else if (pick < 88) begin
			send_eob();
		end else if (pick < 94) begin
			send_byte(CH_NUL);
			repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
			send_eob();
		end else begin
			send_byte(CH_H);
			send_byte(CH_R);
			if ($urandom_range(0, 1))
				send_byte(CH_E);
			send_byte(8'($urandom_range(1, 255)));
		end
	endtask

	// Stops offering beats and waits until every expected result has come out,
	// then waits out SETTLE_CYCLES for beats that produce no result.
	task automatic wait_for_links();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_links.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [11:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		len_limit = v;
		cfg_we <= 1'b0;
	endtask

	// Main sequence: table beats at the reset length, then one phase per length
	// setting. Phase 3 runs with no idling on either side; phase 4 starts with
	// the long receiver hold-off.
	initial begin
		logic [11:0] len_setting;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.end_of_body <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 12'd0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int r = 0; r < OPENING_ROWS; r++)
			drive_beat(OPENING[r]);
		wait_for_links();

		for (int p = 0; p < PHASES; p++) begin
			len_setting = LEN_PLAN[p];
			if (p == 5)
				len_setting = 12'($urandom_range(3, 20));
			if (p == 7)
				len_setting = 12'($urandom_range(1, 4095));
			write_max_len(len_setting);
			steady = (p == 3);
			if (p == 4)
				hold_request = 1'b1;
			counted = 0;
			while (counted < PHASE_BEATS)
				send_fragment();
			wait_for_links();
		end
		steady = 1'b0;

		repeat (END_WAIT) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
